// ===== design/tlca_pkg.sv =====
// shared types, constants and helper functions of the lca engine
// no dependencies; imported by tlca_mem and tree_lca_binary_lifting_top
`default_nettype none

package tlca_pkg;

	localparam int ID_W        = 8;
	localparam int DEPTH_W     = 8;
	localparam int LEN_W       = DEPTH_W + 1;
	localparam int MAX_NODES   = 256;
	localparam int LIFT_LEVELS = 8;
	localparam int NODE_W      = $clog2(MAX_NODES);
	localparam int LVL_W       = $clog2(LIFT_LEVELS);
	localparam int LIFT_DEPTH  = MAX_NODES * LIFT_LEVELS;
	localparam int LIFT_AW     = $clog2(LIFT_DEPTH);

	localparam logic [1:0] KIND_LOAD  = 2'd0;
	localparam logic [1:0] KIND_BUILD = 2'd1;
	localparam logic [1:0] KIND_QUERY = 2'd2;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_B_START,
		ST_B0_RD,
		ST_B0_WR,
		ST_BK_RD1,
		ST_BK_RD2,
		ST_BK_WR,
		ST_Q_RD,
		ST_Q_ORDER,
		ST_Q_LIFT,
		ST_Q_LIFT_W,
		ST_Q_CHECK,
		ST_Q_CLIMB,
		ST_Q_CLIMB_W,
		ST_Q_PARENT,
		ST_Q_PARENT_W,
		ST_Q_DEPTH,
		ST_Q_DONE
	} state_t;

	typedef struct packed {
		logic [ID_W-1:0]    parent;
		logic [DEPTH_W-1:0] depth;
	} pd_entry_t;

	typedef struct packed {
		logic                pd_we;
		logic [NODE_W-1:0]   pd_waddr;
		pd_entry_t           pd_wdata;
		logic [NODE_W-1:0]   pd_raddr0;
		logic [NODE_W-1:0]   pd_raddr1;
		logic                lift_we;
		logic [LIFT_AW-1:0]  lift_waddr;
		logic [ID_W-1:0]     lift_wdata;
		logic [LIFT_AW-1:0]  lift_raddr0;
		logic [LIFT_AW-1:0]  lift_raddr1;
	} mem_req_t;

	typedef struct packed {
		pd_entry_t       pd_rd0;
		pd_entry_t       pd_rd1;
		logic [ID_W-1:0] lift_rd0;
		logic [ID_W-1:0] lift_rd1;
	} mem_rsp_t;

	// out-of-range node numbers read as the sentinel
	function automatic logic [NODE_W-1:0] node_ix(input logic [ID_W-1:0] v);
		if (int'(v) < MAX_NODES)
			return NODE_W'(v);
		else
			return '0;
	endfunction

	function automatic logic [LIFT_AW-1:0] lift_addr(input logic [NODE_W-1:0] n,
	                                                 input logic [LVL_W-1:0] k);
		return LIFT_AW'(n) * LIFT_AW'(LIFT_LEVELS) + LIFT_AW'(k);
	endfunction

	function automatic logic [NODE_W-1:0] build_last(input logic [ID_W-1:0] cnt);
		if (int'(cnt) > MAX_NODES - 1)
			return NODE_W'(MAX_NODES - 1);
		else
			return NODE_W'(cnt);
	endfunction

endpackage

`default_nettype wire

// ===== design/tlca_mem.sv =====
// parent/depth memory and lift memory, each one write port and two read ports
// uses tlca_pkg for the request and response structs
`default_nettype none

module tlca_mem
	import tlca_pkg::*;
(
	input  wire logic     clk,
	input  wire mem_req_t req,
	output mem_rsp_t      rsp
);

	pd_entry_t       pd_mem   [MAX_NODES];
	logic [ID_W-1:0] lift_mem [LIFT_DEPTH];

	always_ff @(posedge clk) begin
		if (req.pd_we)
			pd_mem[req.pd_waddr] <= req.pd_wdata;
		if (req.lift_we)
			lift_mem[req.lift_waddr] <= req.lift_wdata;
		rsp.pd_rd0   <= pd_mem[req.pd_raddr0];
		rsp.pd_rd1   <= pd_mem[req.pd_raddr1];
		rsp.lift_rd0 <= lift_mem[req.lift_raddr0];
		rsp.lift_rd1 <= lift_mem[req.lift_raddr1];
	end

endmodule

`default_nettype wire

// ===== design/tree_lca_binary_lifting_top.sv =====
// lowest-common-ancestor engine, top level: sequencer, config register, output register
// uses tlca_pkg and instantiates tlca_mem
`default_nettype none

// Binary-lifting LCA engine. The host loads each node's parent and depth (kind 0),
// issues a build (kind 1) that fills the 2^k ancestor table for nodes 1..node_count,
// then sends query pairs (kind 2); each query gives one transfer on the output
// with the common ancestor and the edge count between the two nodes. Loads and
// builds give no output. After reset the block clears its memories, one write
// per lift table entry, and holds in_stall high meanwhile; config writes are
// taken at any time. Items run one at a time. A build first copies the parent
// column into level 0; every higher lift entry then needs two dependent reads
// of the lift memory before its write. A query first lifts the deeper node: the
// walk visits the eight lift levels, reading the lift memory only where the depth
// difference has a set bit; if the lifted node does not meet the other one, the
// climb then makes one paired read per level. A finished result sits in the
// output register while the next item is taken.
module tree_lca_binary_lifting_top
	import tlca_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	// configuration
	input  wire logic               cfg_we,
	input  wire logic [ID_W-1:0]    cfg_data,
	// input channel
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         kind,
	input  wire logic [ID_W-1:0]    node_id,
	input  wire logic [ID_W-1:0]    parent_id,
	input  wire logic [DEPTH_W-1:0] node_depth,
	input  wire logic [ID_W-1:0]    query_a,
	input  wire logic [ID_W-1:0]    query_b,
	// output channel
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [ID_W-1:0]         common_ancestor,
	output logic [LEN_W-1:0]        path_length
);

	localparam logic [LIFT_AW-1:0] CLR_LAST = LIFT_AW'(LIFT_DEPTH - 1);
	localparam logic [LVL_W-1:0]   LVL_LAST = LVL_W'(LIFT_LEVELS - 1);

	state_t state_q, state_d;

	mem_req_t mem_req;
	mem_rsp_t mem_rsp;

	// control registers
	logic [LIFT_AW-1:0] clr_q, clr_d;
	logic [ID_W-1:0]    node_count_q;
	logic [NODE_W-1:0]  idx_q, idx_d;
	logic [LVL_W-1:0]   lvl_q, lvl_d;
	logic               out_valid_q;

	// query working registers
	logic [NODE_W-1:0]      qa_q, qa_d;
	logic [NODE_W-1:0]      qb_q, qb_d;
	logic [NODE_W-1:0]      c_q, c_d;
	logic [DEPTH_W-1:0]     da_q, da_d;
	logic [DEPTH_W-1:0]     db_q, db_d;
	logic [LIFT_LEVELS-1:0] diff_q, diff_d;

	// output register payload
	logic [ID_W-1:0]  ca_q;
	logic [LEN_W-1:0] len_q;

	logic              out_free;
	logic              out_load;
	logic [NODE_W-1:0] last;
	logic [LEN_W-1:0]  len_sum;
	logic [LEN_W-1:0]  len_twice;
	logic [LEN_W-1:0]  len_val;

	tlca_mem u_mem (
		.clk (clk),
		.req (mem_req),
		.rsp (mem_rsp)
	);

	assign in_stall        = (state_q != ST_IDLE);
	assign out_valid       = out_valid_q;
	assign common_ancestor = ca_q;
	assign path_length     = len_q;

	// output register can take a result when empty or emptying this cycle
	assign out_free = !out_valid_q || !out_stall;
	assign last     = build_last(node_count_q);

	// depth(a) + depth(b) - 2*depth(c), floored at zero
	assign len_sum   = LEN_W'(da_q) + LEN_W'(db_q);
	assign len_twice = LEN_W'(mem_rsp.pd_rd0.depth) << 1;
	assign len_val   = (len_sum < len_twice) ? '0 : (len_sum - len_twice);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		logic [NODE_W-1:0] pa;
		logic [NODE_W-1:0] pb;
		pa       = node_ix(mem_rsp.lift_rd0);
		pb       = node_ix(mem_rsp.lift_rd1);
		state_d  = state_q;
		mem_req  = '0;
		clr_d    = clr_q;
		idx_d    = idx_q;
		lvl_d    = lvl_q;
		qa_d     = qa_q;
		qb_d     = qb_q;
		c_d      = c_q;
		da_d     = da_q;
		db_d     = db_q;
		diff_d   = diff_q;
		out_load = 1'b0;
		case (state_q)
			// zero every lift entry; the parent/depth memory wraps and is zeroed too
			ST_CLEAR: begin
				mem_req.lift_we    = 1'b1;
				mem_req.lift_waddr = clr_q;
				mem_req.lift_wdata = '0;
				mem_req.pd_we      = 1'b1;
				mem_req.pd_waddr   = clr_q[NODE_W-1:0];
				mem_req.pd_wdata   = '0;
				clr_d              = clr_q + LIFT_AW'(1);
				if (clr_q == CLR_LAST)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					case (kind)
						KIND_LOAD: begin
							// node 0 and out-of-range nodes are not written
							if (node_id != '0 && int'(node_id) < MAX_NODES) begin
								mem_req.pd_we           = 1'b1;
								mem_req.pd_waddr        = NODE_W'(node_id);
								mem_req.pd_wdata.parent = parent_id;
								mem_req.pd_wdata.depth  = node_depth;
							end
						end
						KIND_BUILD: state_d = ST_B_START;
						KIND_QUERY: begin
							qa_d    = node_ix(query_a);
							qb_d    = node_ix(query_b);
							state_d = ST_Q_RD;
						end
						default: ;
					endcase
				end
			end
			ST_B_START: begin
				if (last == '0) begin
					state_d = ST_IDLE;
				end else begin
					idx_d   = NODE_W'(1);
					lvl_d   = '0;
					state_d = ST_B0_RD;
				end
			end
			// level 0 is the parent column
			ST_B0_RD: begin
				mem_req.pd_raddr0 = idx_q;
				state_d           = ST_B0_WR;
			end
			ST_B0_WR: begin
				mem_req.lift_we    = 1'b1;
				mem_req.lift_waddr = lift_addr(idx_q, '0);
				mem_req.lift_wdata = mem_rsp.pd_rd0.parent;
				if (idx_q == last) begin
					idx_d   = NODE_W'(1);
					lvl_d   = LVL_W'(1);
					state_d = ST_BK_RD1;
				end else begin
					idx_d   = idx_q + NODE_W'(1);
					state_d = ST_B0_RD;
				end
			end
			// level k: ancestor of the level k-1 ancestor, two chained reads
			ST_BK_RD1: begin
				mem_req.lift_raddr0 = lift_addr(idx_q, lvl_q - LVL_W'(1));
				state_d             = ST_BK_RD2;
			end
			ST_BK_RD2: begin
				mem_req.lift_raddr0 = lift_addr(pa, lvl_q - LVL_W'(1));
				state_d             = ST_BK_WR;
			end
			ST_BK_WR: begin
				mem_req.lift_we    = 1'b1;
				mem_req.lift_waddr = lift_addr(idx_q, lvl_q);
				mem_req.lift_wdata = mem_rsp.lift_rd0;
				if (idx_q == last) begin
					if (lvl_q == LVL_LAST) begin
						state_d = ST_IDLE;
					end else begin
						lvl_d   = lvl_q + LVL_W'(1);
						idx_d   = NODE_W'(1);
						state_d = ST_BK_RD1;
					end
				end else begin
					idx_d   = idx_q + NODE_W'(1);
					state_d = ST_BK_RD1;
				end
			end
			ST_Q_RD: begin
				mem_req.pd_raddr0 = qa_q;
				mem_req.pd_raddr1 = qb_q;
				state_d           = ST_Q_ORDER;
			end
			// make a the deeper node
			ST_Q_ORDER: begin
				da_d = mem_rsp.pd_rd0.depth;
				db_d = mem_rsp.pd_rd1.depth;
				if (mem_rsp.pd_rd0.depth < mem_rsp.pd_rd1.depth) begin
					qa_d   = qb_q;
					qb_d   = qa_q;
					diff_d = LIFT_LEVELS'(mem_rsp.pd_rd1.depth - mem_rsp.pd_rd0.depth);
				end else begin
					diff_d = LIFT_LEVELS'(mem_rsp.pd_rd0.depth - mem_rsp.pd_rd1.depth);
				end
				lvl_d   = '0;
				state_d = ST_Q_LIFT;
			end
			ST_Q_LIFT: begin
				if (diff_q[lvl_q]) begin
					mem_req.lift_raddr0 = lift_addr(qa_q, lvl_q);
					state_d             = ST_Q_LIFT_W;
				end else if (lvl_q == LVL_LAST) begin
					state_d = ST_Q_CHECK;
				end else begin
					lvl_d = lvl_q + LVL_W'(1);
				end
			end
			ST_Q_LIFT_W: begin
				qa_d = pa;
				if (lvl_q == LVL_LAST) begin
					state_d = ST_Q_CHECK;
				end else begin
					lvl_d   = lvl_q + LVL_W'(1);
					state_d = ST_Q_LIFT;
				end
			end
			ST_Q_CHECK: begin
				if (qa_q == qb_q) begin
					c_d     = qa_q;
					state_d = ST_Q_DEPTH;
				end else begin
					lvl_d   = LVL_LAST;
					state_d = ST_Q_CLIMB;
				end
			end
			ST_Q_CLIMB: begin
				mem_req.lift_raddr0 = lift_addr(qa_q, lvl_q);
				mem_req.lift_raddr1 = lift_addr(qb_q, lvl_q);
				state_d             = ST_Q_CLIMB_W;
			end
			ST_Q_CLIMB_W: begin
				if (pa != pb) begin
					qa_d = pa;
					qb_d = pb;
				end
				if (lvl_q == '0) begin
					state_d = ST_Q_PARENT;
				end else begin
					lvl_d   = lvl_q - LVL_W'(1);
					state_d = ST_Q_CLIMB;
				end
			end
			ST_Q_PARENT: begin
				mem_req.pd_raddr0 = qa_q;
				state_d           = ST_Q_PARENT_W;
			end
			ST_Q_PARENT_W: begin
				c_d     = node_ix(mem_rsp.pd_rd0.parent);
				state_d = ST_Q_DEPTH;
			end
			ST_Q_DEPTH: begin
				mem_req.pd_raddr0 = c_q;
				state_d           = ST_Q_DONE;
			end
			// keep the depth read steady while the output register is full
			ST_Q_DONE: begin
				mem_req.pd_raddr0 = c_q;
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q        <= '0;
			node_count_q <= ID_W'(255);
			idx_q        <= '0;
			lvl_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			clr_q <= clr_d;
			idx_q <= idx_d;
			lvl_q <= lvl_d;
			if (cfg_we)
				node_count_q <= cfg_data;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		qa_q   <= qa_d;
		qb_q   <= qb_d;
		c_q    <= c_d;
		da_q   <= da_d;
		db_q   <= db_d;
		diff_q <= diff_d;
		if (out_load) begin
			ca_q  <= ID_W'(c_q);
			len_q <= len_val;
		end
	end

`ifndef NO_ASSERTIONS
	// a new result only comes out of the final query step
	a_result_from_query: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_Q_DONE))
		else $error("result raised outside query completion");

	// the clearing pass runs once after reset and never comes back
	a_clear_once: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_CLEAR |=> state_q != ST_CLEAR)
		else $error("clearing pass restarted");

	// higher build levels never read below level 0
	a_build_level: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BK_RD1 || state_q == ST_BK_RD2 || state_q == ST_BK_WR)
			|-> lvl_q != '0)
		else $error("build level underflow");
`endif

endmodule

`default_nettype wire
